@@ rtl/core/tapid_pkg.sv @@
// Shared types, register indexes, action codes, a saturation helper and a
// per-axis gain select for the three-axis PID core. No dependencies.
`default_nettype none

package tapid_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ACC_W      = 66;
    localparam int DIV_STEPS  = 64;
    localparam int ROOT_STEPS = 32;

    localparam logic [31:0] ACC_CAP  = 32'h7FFF_FFFF;
    localparam logic [63:0] RATE_CAP = 64'h0000_0100_0000_0000;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_POS_KP    = 3'd0;
    localparam reg_idx_t REG_POS_KI    = 3'd1;
    localparam reg_idx_t REG_POS_KD    = 3'd2;
    localparam reg_idx_t REG_VEL_KP    = 3'd3;
    localparam reg_idx_t REG_VEL_KI    = 3'd4;
    localparam reg_idx_t REG_VEL_KD    = 3'd5;
    localparam reg_idx_t REG_INT_LIMIT = 3'd6;
    localparam reg_idx_t REG_ACC_LIMIT = 3'd7;

    localparam logic [1:0] ACT_NORMAL   = 2'd0;
    localparam logic [1:0] ACT_RESET    = 2'd1;
    localparam logic [1:0] ACT_VEL_ONLY = 2'd2;

    typedef struct packed {
        logic start;
        logic sqrt_op;
    } ds_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(signed'({1'b0, ACC_CAP}));
        lo = -hi;
        if (v > hi)
            return signed'(ACC_CAP);
        else if (v < lo)
            return -signed'(ACC_CAP);
        else
            return v[31:0];
    endfunction

    function automatic logic [15:0] gain16(input logic [47:0] g, input logic [1:0] ax);
        logic [15:0] r;
        case (ax)
            2'd0:    r = g[15:0];
            2'd1:    r = g[31:16];
            2'd2:    r = g[47:32];
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tapid_divsqrt.sv @@
// Bit-serial unsigned divider and integer square root, one step a cycle.
// Depends on tapid_pkg.
`default_nettype none

module tapid_divsqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  tapid_pkg::ds_req_t req,
    input  logic [63:0]       num,
    input  logic [31:0]       den,
    output logic              done,
    output logic [63:0]       res
);
    import tapid_pkg::*;

    logic        busy_reg;
    logic        sqrt_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [35:0] rem_reg;
    logic [63:0] quo_reg;
    logic [31:0] root_reg;
    logic [31:0] den_reg;

    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_rem;
    logic [35:0] sq_sh;
    logic [35:0] sq_trial;
    logic        sq_ge;

    always_comb
    begin
        div_sh   = {rem_reg[31:0], quo_reg[63]};
        div_ge   = div_sh >= {1'b0, den_reg};
        div_rem  = div_ge ? div_sh - {1'b0, den_reg} : div_sh;
        sq_sh    = {rem_reg[33:0], quo_reg[63:62]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            root_reg <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.sqrt_op;
                cnt_reg  <= req.sqrt_op ? 7'(ROOT_STEPS) : 7'(DIV_STEPS);
                rem_reg  <= '0;
                quo_reg  <= num;
                root_reg <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (sqrt_reg)
                begin
                    rem_reg  <= sq_ge ? sq_sh - sq_trial : sq_sh;
                    root_reg <= {root_reg[30:0], sq_ge};
                    quo_reg  <= {quo_reg[61:0], 2'b00};
                end
                else
                begin
                    rem_reg <= 36'(div_rem);
                    quo_reg <= {quo_reg[62:0], div_ge};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = sqrt_reg ? {32'd0, root_reg} : quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/three_axis_pid_anti_windup_core.sv @@
// Three-axis PID with conditional-integration anti-windup, one shared
// multiplier and one shared bit-serial divide/root unit under a sequencer.
// A zero integral gain skips the divide for that axis and clears its integrator. One word in flight;
// the next is taken the cycle after the result is registered. Reset clears gains,
// limits, integrators and previous errors, sets first step.
`default_nettype none

module three_axis_pid_anti_windup_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [215:0]        s_tdata,   // pos_err_x/y/z, vel_err_x/y/z, step_time
    input  logic [1:0]          s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,   // acc_x, acc_y, acc_z
    output logic                m_tuser,   // limited
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  tapid_pkg::reg_idx_t cfg_index,
    input  logic [59:0]         cfg_data
);
    import tapid_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE, ST_RATE_WAIT, ST_DMUL, ST_DACC, ST_DFIN,
        ST_SQMUL, ST_SQACC, ST_LMUL, ST_LCMP, ST_ROOT_WAIT,
        ST_SCMUL, ST_SCDIV, ST_SCWAIT, ST_AMUL, ST_AACC, ST_AFIN,
        ST_IMUL, ST_IUPD, ST_BWAIT, ST_INEXT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [1:0]  ax_reg;
    logic [1:0]  tm_reg;
    logic        vk_reg;
    logic        csel_reg;
    logic        pass_reg;
    logic        sat_reg;
    logic        limited_reg;
    logic        first_reg;
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [47:0] pos_kp_reg, pos_ki_reg, pos_kd_reg;
    logic [47:0] vel_kp_reg, vel_ki_reg, vel_kd_reg;
    logic [59:0] int_lim_reg;
    logic [31:0] acc_lim_reg;

    logic signed [31:0] pint_reg [3];
    logic signed [31:0] vint_reg [3];
    logic signed [31:0] prev_p_reg [3];
    logic signed [31:0] prev_v_reg [3];

    logic signed [31:0] pe_reg [3];
    logic signed [31:0] ve_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] a_reg [3];
    logic [20:0]        dt_reg;
    logic signed [41:0] rp_reg, rv_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [31:0]        n_reg;
    logic               neg_reg;

    ds_req_t     ds_req;
    logic [63:0] ds_num;
    logic [31:0] ds_den;
    logic        ds_done;
    logic [63:0] ds_res;

    logic [1:0]  s_act;
    logic [23:0] lim;
    logic signed [31:0] pe_cur, ve_cur, e_cur, int_cur, d_cur, v_cur;
    logic [15:0] ki_cur;
    logic [2:0]  lidx;
    logic [9:0]  ilim;
    logic signed [32:0] diff;
    logic [32:0] diff_mag;
    logic signed [32:0] opa, opb;
    logic signed [ACC_W-1:0] prod_c;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] inc;
    logic [ACC_W-1:0] prod_mag;
    logic        over;
    logic        allow;
    logic [40:0] rate_mag;
    logic signed [41:0] rate_val;
    logic signed [31:0] scaled;
    logic [31:0] bnd;
    logic signed [ACC_W-1:0] bnd_w;
    logic signed [31:0] integ_cl;

    assign s_act    = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        lim      = csel_reg ? {acc_lim_reg[15:0], 8'd0} : {acc_lim_reg[31:16], 8'd0};
        pe_cur   = pe_reg[ax_reg];
        ve_cur   = ve_reg[ax_reg];
        d_cur    = d_reg[ax_reg];
        v_cur    = csel_reg ? a_reg[ax_reg] : d_reg[ax_reg];
        e_cur    = vk_reg ? ve_cur : pe_cur;
        int_cur  = vk_reg ? vint_reg[ax_reg] : pint_reg[ax_reg];
        ki_cur   = vk_reg ? gain16(vel_ki_reg, ax_reg) : gain16(pos_ki_reg, ax_reg);
        lidx     = vk_reg ? 3'd3 + {1'b0, ax_reg} : {1'b0, ax_reg};
        ilim     = int_lim_reg[10*lidx +: 10];
        diff     = vk_reg ? 33'(ve_cur) - 33'(prev_v_reg[ax_reg])
                          : 33'(pe_cur) - 33'(prev_p_reg[ax_reg]);
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        prod_mag = prod_reg[ACC_W-1] ? ACC_W'(-prod_reg) : ACC_W'(prod_reg);
        over     = acc_reg > prod_reg;
        inc      = prod_reg >>> (36 - FRAC_BITS);
        allow    = !sat_reg
                   || (!e_cur[31] && e_cur != 32'sd0 && int_cur[31])
                   || (e_cur[31] && !int_cur[31] && int_cur != 32'sd0);
        rate_mag = (ds_res > RATE_CAP) ? RATE_CAP[40:0] : ds_res[40:0];
        rate_val = neg_reg ? -signed'({1'b0, rate_mag}) : signed'({1'b0, rate_mag});
        scaled   = neg_reg ? -signed'(ds_res[31:0]) : signed'(ds_res[31:0]);
        bnd      = (ds_res > {32'd0, ACC_CAP}) ? ACC_CAP : ds_res[31:0];
        bnd_w    = ACC_W'(signed'({1'b0, bnd}));
        if (acc_reg > bnd_w)
            integ_cl = signed'(bnd);
        else if (acc_reg < -bnd_w)
            integ_cl = -signed'(bnd);
        else
            integ_cl = acc_reg[31:0];
    end

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (state_reg)
            ST_DMUL:
            begin
                case (tm_reg)
                    2'd0:
                    begin
                        opa = signed'({17'd0, gain16(pos_kd_reg, ax_reg)});
                        opb = signed'({12'd0, rp_reg[20:0]});
                    end
                    2'd1:
                    begin
                        opa = signed'({17'd0, gain16(pos_kd_reg, ax_reg)});
                        opb = 33'(signed'(rp_reg[41:21]));
                    end
                    2'd2:
                    begin
                        opa = signed'({17'd0, gain16(vel_kd_reg, ax_reg)});
                        opb = signed'({12'd0, rv_reg[20:0]});
                    end
                    default:
                    begin
                        opa = signed'({17'd0, gain16(vel_kd_reg, ax_reg)});
                        opb = 33'(signed'(rv_reg[41:21]));
                    end
                endcase
            end
            ST_AMUL:
            begin
                case (tm_reg)
                    2'd0:
                    begin
                        opa = signed'({17'd0, gain16(pos_kp_reg, ax_reg)});
                        opb = 33'(pe_cur);
                    end
                    2'd1:
                    begin
                        opa = signed'({17'd0, gain16(pos_ki_reg, ax_reg)});
                        opb = 33'(pint_reg[ax_reg]);
                    end
                    2'd2:
                    begin
                        opa = signed'({17'd0, gain16(vel_kp_reg, ax_reg)});
                        opb = 33'(ve_cur);
                    end
                    default:
                    begin
                        opa = signed'({17'd0, gain16(vel_ki_reg, ax_reg)});
                        opb = 33'(vint_reg[ax_reg]);
                    end
                endcase
            end
            ST_SQMUL:
            begin
                opa = 33'(v_cur);
                opb = 33'(v_cur);
            end
            ST_LMUL:
            begin
                opa = signed'({9'd0, lim});
                opb = signed'({9'd0, lim});
            end
            ST_SCMUL:
            begin
                opa = 33'(v_cur);
                opb = signed'({9'd0, lim});
            end
            ST_IMUL:
            begin
                opa = 33'(e_cur);
                opb = signed'({12'd0, dt_reg});
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        prod_c = opa * opb;
    end

    always_comb
    begin
        case (state_reg)
            ST_DACC: term = tm_reg[0] ? (prod_reg <<< 21) : prod_reg;
            ST_AACC: term = tm_reg[0] ? (prod_reg >>> (FRAC_BITS - 8)) : (prod_reg >>> 8);
            default: term = prod_reg;
        endcase
    end

    always_comb
    begin
        ds_req = '0;
        ds_num = '0;
        ds_den = '0;
        case (state_reg)
            ST_RATE:
            begin
                ds_req.start = !first_reg;
                ds_num       = {11'd0, diff_mag, 20'd0};
                ds_den       = {11'd0, dt_reg};
            end
            ST_LCMP:
            begin
                ds_req.start   = over && (!csel_reg || pass_reg);
                ds_req.sqrt_op = 1'b1;
                ds_num         = acc_reg[63:0];
            end
            ST_SCDIV:
            begin
                ds_req.start = 1'b1;
                ds_num       = prod_mag[63:0];
                ds_den       = n_reg;
            end
            ST_IUPD:
            begin
                ds_req.start = (ki_cur != 16'd0);
                ds_num       = 64'(ilim) << (4 + FRAC_BITS);
                ds_den       = {16'd0, ki_cur};
            end
            default:
            begin
                ds_req = '0;
            end
        endcase
    end

    tapid_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .num   (ds_num),
        .den   (ds_den),
        .done  (ds_done),
        .res   (ds_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ax_reg       <= '0;
            tm_reg       <= '0;
            vk_reg       <= 1'b0;
            csel_reg     <= 1'b0;
            pass_reg     <= 1'b0;
            sat_reg      <= 1'b0;
            limited_reg  <= 1'b0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            pos_kp_reg   <= '0;
            pos_ki_reg   <= '0;
            pos_kd_reg   <= '0;
            vel_kp_reg   <= '0;
            vel_ki_reg   <= '0;
            vel_kd_reg   <= '0;
            int_lim_reg  <= '0;
            acc_lim_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pint_reg[i]   <= '0;
                vint_reg[i]   <= '0;
                prev_p_reg[i] <= '0;
                prev_v_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POS_KP:    pos_kp_reg  <= cfg_data[47:0];
                    REG_POS_KI:    pos_ki_reg  <= cfg_data[47:0];
                    REG_POS_KD:    pos_kd_reg  <= cfg_data[47:0];
                    REG_VEL_KP:    vel_kp_reg  <= cfg_data[47:0];
                    REG_VEL_KI:    vel_ki_reg  <= cfg_data[47:0];
                    REG_VEL_KD:    vel_kd_reg  <= cfg_data[47:0];
                    REG_INT_LIMIT: int_lim_reg <= cfg_data;
                    REG_ACC_LIMIT: acc_lim_reg <= cfg_data[31:0];
                    default:       acc_lim_reg <= acc_lim_reg;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_act == ACT_RESET)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pint_reg[i]   <= '0;
                                vint_reg[i]   <= '0;
                                prev_p_reg[i] <= '0;
                                prev_v_reg[i] <= '0;
                            end
                            first_reg <= 1'b1;
                        end
                        if (s_act == ACT_VEL_ONLY)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pint_reg[i]   <= '0;
                                prev_p_reg[i] <= '0;
                            end
                        end
                        ax_reg    <= '0;
                        vk_reg    <= 1'b0;
                        state_reg <= ST_RATE;
                    end
                end
                ST_RATE:
                begin
                    if (first_reg)
                    begin
                        if (vk_reg)
                        begin
                            vk_reg    <= 1'b0;
                            tm_reg    <= '0;
                            state_reg <= ST_DMUL;
                        end
                        else
                            vk_reg <= 1'b1;
                    end
                    else
                        state_reg <= ST_RATE_WAIT;
                end
                ST_RATE_WAIT:
                begin
                    if (ds_done)
                    begin
                        if (vk_reg)
                        begin
                            vk_reg    <= 1'b0;
                            tm_reg    <= '0;
                            state_reg <= ST_DMUL;
                        end
                        else
                        begin
                            vk_reg    <= 1'b1;
                            state_reg <= ST_RATE;
                        end
                    end
                end
                ST_DMUL: state_reg <= ST_DACC;
                ST_DACC:
                begin
                    if (tm_reg == 2'd3)
                        state_reg <= ST_DFIN;
                    else
                    begin
                        tm_reg    <= tm_reg + 2'd1;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_DFIN:
                begin
                    prev_p_reg[ax_reg] <= pe_cur;
                    prev_v_reg[ax_reg] <= ve_cur;
                    tm_reg <= '0;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        first_reg <= 1'b0;
                        csel_reg  <= 1'b0;
                        state_reg <= ST_SQMUL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_RATE;
                    end
                end
                ST_SQMUL: state_reg <= ST_SQACC;
                ST_SQACC:
                begin
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= ST_LMUL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_SQMUL;
                    end
                end
                ST_LMUL: state_reg <= ST_LCMP;
                ST_LCMP:
                begin
                    tm_reg <= '0;
                    if (!csel_reg)
                    begin
                        pass_reg  <= 1'b0;
                        state_reg <= over ? ST_ROOT_WAIT : ST_AMUL;
                    end
                    else if (!pass_reg)
                    begin
                        sat_reg   <= over;
                        vk_reg    <= 1'b0;
                        state_reg <= ST_IMUL;
                    end
                    else
                    begin
                        limited_reg <= over;
                        state_reg   <= over ? ST_ROOT_WAIT : ST_OUT;
                    end
                end
                ST_ROOT_WAIT:
                begin
                    if (ds_done)
                        state_reg <= ST_SCMUL;
                end
                ST_SCMUL: state_reg <= ST_SCDIV;
                ST_SCDIV: state_reg <= ST_SCWAIT;
                ST_SCWAIT:
                begin
                    if (ds_done)
                    begin
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg    <= '0;
                            tm_reg    <= '0;
                            state_reg <= csel_reg ? ST_OUT : ST_AMUL;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_SCMUL;
                        end
                    end
                end
                ST_AMUL: state_reg <= ST_AACC;
                ST_AACC:
                begin
                    if (tm_reg == 2'd3)
                        state_reg <= ST_AFIN;
                    else
                    begin
                        tm_reg    <= tm_reg + 2'd1;
                        state_reg <= ST_AMUL;
                    end
                end
                ST_AFIN:
                begin
                    tm_reg <= '0;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        csel_reg  <= 1'b1;
                        state_reg <= ST_SQMUL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_AMUL;
                    end
                end
                ST_IMUL: state_reg <= ST_IUPD;
                ST_IUPD:
                begin
                    if (ki_cur == 16'd0)
                    begin
                        if (vk_reg)
                            vint_reg[ax_reg] <= '0;
                        else
                            pint_reg[ax_reg] <= '0;
                        state_reg <= ST_INEXT;
                    end
                    else
                        state_reg <= ST_BWAIT;
                end
                ST_BWAIT:
                begin
                    if (ds_done)
                    begin
                        if (vk_reg)
                            vint_reg[ax_reg] <= integ_cl;
                        else
                            pint_reg[ax_reg] <= integ_cl;
                        state_reg <= ST_INEXT;
                    end
                end
                ST_INEXT:
                begin
                    if (!vk_reg)
                    begin
                        vk_reg    <= 1'b1;
                        state_reg <= ST_IMUL;
                    end
                    else
                    begin
                        vk_reg <= 1'b0;
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg    <= '0;
                            tm_reg    <= '0;
                            pass_reg  <= 1'b1;
                            csel_reg  <= 1'b0;
                            state_reg <= ST_AMUL;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= ST_IMUL;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, a_reg[2][24:0], a_reg[1][24:0], a_reg[0][24:0]};
                        m_tuser_reg  <= limited_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pe_reg[i] <= (s_act == ACT_VEL_ONLY) ? 32'sd0 : s_tdata[32*i +: 32];
                        ve_reg[i] <= s_tdata[96 + 32*i +: 32];
                    end
                    dt_reg <= (s_tdata[212:192] == 21'd0) ? 21'd1 : s_tdata[212:192];
                end
            end
            ST_RATE:
            begin
                neg_reg <= diff[32];
                if (first_reg)
                begin
                    if (vk_reg)
                        rv_reg <= '0;
                    else
                        rp_reg <= '0;
                end
            end
            ST_RATE_WAIT:
            begin
                if (ds_done)
                begin
                    if (vk_reg)
                        rv_reg <= rate_val;
                    else
                        rp_reg <= rate_val;
                end
            end
            ST_DMUL:
            begin
                prod_reg <= prod_c;
                if (tm_reg == 2'd0)
                    acc_reg <= '0;
            end
            ST_AMUL:
            begin
                prod_reg <= prod_c;
                if (tm_reg == 2'd0)
                    acc_reg <= ACC_W'(d_cur);
            end
            ST_SQMUL:
            begin
                prod_reg <= prod_c;
                if (ax_reg == 2'd0)
                    acc_reg <= '0;
            end
            ST_LMUL:  prod_reg <= prod_c;
            ST_SCMUL: prod_reg <= prod_c;
            ST_IMUL:  prod_reg <= prod_c;
            ST_DACC:  acc_reg <= acc_reg + term;
            ST_AACC:  acc_reg <= acc_reg + term;
            ST_SQACC: acc_reg <= acc_reg + term;
            ST_DFIN:  d_reg[ax_reg] <= sat32(acc_reg >>> 8);
            ST_AFIN:  a_reg[ax_reg] <= sat32(acc_reg);
            ST_ROOT_WAIT:
            begin
                if (ds_done)
                    n_reg <= (ds_res[31:0] == 32'd0) ? 32'd1 : ds_res[31:0];
            end
            ST_SCDIV: neg_reg <= prod_reg[ACC_W-1];
            ST_SCWAIT:
            begin
                if (ds_done)
                begin
                    if (csel_reg)
                        a_reg[ax_reg] <= scaled;
                    else
                        d_reg[ax_reg] <= scaled;
                end
            end
            ST_IUPD:  acc_reg <= ACC_W'(int_cur) + (allow ? inc : '0);
            default:  acc_reg <= acc_reg;
        endcase
    end

endmodule

`default_nettype wire
